FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the command frame checker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CFC_ASSERT_IMP(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CFC_ASSERT_NXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CFC_ASSERT_IMP(lbl, c, r, ante, cons)
`define CFC_ASSERT_NXT(lbl, c, r, ante, cons)
`endif

`endif

FILE: rtl/cfc_pkg.sv
// ---------------------------------------------------------------------------
// cfc_pkg
// Types, constants and CRC byte functions for the command frame checker.
// ---------------------------------------------------------------------------
package cfc_pkg;

  localparam int LENGTH_BITS_DEF = 10;
  localparam int PLEN_W          = 10;
  localparam int MIN_FRAME       = 18;
  localparam int RQ_DEPTH        = 4;

  localparam logic [15:0] HCRC_INIT = 16'h3AA3;
  localparam logic [15:0] HCRC_POLY = 16'hA001;
  localparam logic [31:0] FCRC_INIT = 32'h0000_3AA3;
  localparam logic [31:0] FCRC_POLY = 32'hEDB8_8320;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_START = 3'd1;
  localparam logic [2:0] ERR_LEN   = 3'd2;
  localparam logic [2:0] ERR_HCRC  = 3'd3;
  localparam logic [2:0] ERR_FCRC  = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic              result_kind;
    logic [7:0]        payload_byte;
    logic              frame_ok;
    logic [2:0]        error_code;
    logic [7:0]        command_type;
    logic [15:0]       sequence_number;
    logic [7:0]        command_set;
    logic [7:0]        command_id;
    logic [PLEN_W-1:0] payload_length;
    logic              last_of_run;
  } result_t;

  typedef struct packed {
    logic pay;
    logic vrd;
  } rq_push_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ HCRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ FCRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

FILE: rtl/cfc_core.sv
// ---------------------------------------------------------------------------
// cfc_core
// Per-frame state, CRC updates, delay window and result formation.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfc_core #(
  parameter int LENGTH_BITS = cfc_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  logic [7:0]        item_byte,
  input  logic              item_eof,
  input  logic [7:0]        start_byte,
  output cfc_pkg::rq_push_t push,
  output cfc_pkg::result_t  pay_res,
  output cfc_pkg::result_t  vrd_res
);
  import cfc_pkg::*;

  localparam int CW = LENGTH_BITS + 1;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  logic [CW-1:0]          byte_count_r, byte_count_nxt, len;
  logic [15:0]            header_crc_r, header_crc_nxt;
  logic [31:0]            frame_crc_r, frame_crc_nxt;
  logic [7:0]             window_r [4];
  logic [LENGTH_BITS-1:0] length_r, length_nxt;
  logic [15:0]            length_word;
  logic [39:0]            header_r, header_nxt;
  logic [2:0]             first_err_r, first_err_nxt;
  logic [2:0]             err;
  logic [31:0]            rx_crc;
  logic [7:0]             oldest;

  assign oldest      = window_r[0];
  assign length_word = {item_byte, length_r[7:0]};
  assign rx_crc      = {item_byte, window_r[3], window_r[2], window_r[1]};

  always_comb begin
    first_err_nxt  = first_err_r;
    header_crc_nxt = header_crc_r;
    length_nxt     = length_r;
    header_nxt     = header_r;
    frame_crc_nxt  = frame_crc_r;

    if (byte_count_r == '0 && item_byte != start_byte) begin
      first_err_nxt = ERR_START;
    end
    if (byte_count_r < CW'(10)) begin
      header_crc_nxt = crc16_byte(header_crc_r, item_byte);
    end
    if (byte_count_r == CW'(10) && item_byte != header_crc_r[7:0] &&
        first_err_r == ERR_NONE) begin
      first_err_nxt = ERR_HCRC;
    end
    if (byte_count_r == CW'(11) && item_byte != header_crc_r[15:8] &&
        first_err_r == ERR_NONE) begin
      first_err_nxt = ERR_HCRC;
    end
    if (byte_count_r == CW'(1)) begin
      length_nxt = LENGTH_BITS'(item_byte);
    end
    if (byte_count_r == CW'(2)) begin
      length_nxt = length_word[LENGTH_BITS-1:0];
    end
    if (byte_count_r == CW'(3)) begin
      header_nxt[7:0] = item_byte;
    end
    if (byte_count_r == CW'(8)) begin
      header_nxt[15:8] = item_byte;
    end
    if (byte_count_r == CW'(9)) begin
      header_nxt[23:16] = item_byte;
    end
    if (byte_count_r == CW'(12)) begin
      header_nxt[31:24] = item_byte;
    end
    if (byte_count_r == CW'(13)) begin
      header_nxt[39:32] = item_byte;
    end
    if (byte_count_r >= CW'(4)) begin
      frame_crc_nxt = crc32_byte(frame_crc_r, oldest);
    end
    byte_count_nxt = (byte_count_r != COUNT_MAX) ? byte_count_r + CW'(1) : byte_count_r;
  end

  assign len = byte_count_nxt;

  always_comb begin
    priority if (len < CW'(MIN_FRAME) || first_err_nxt == ERR_START) begin
      err = ERR_START;
    end else if (CW'(length_nxt) != len) begin
      err = ERR_LEN;
    end else if (first_err_nxt == ERR_HCRC) begin
      err = ERR_HCRC;
    end else if (rx_crc != frame_crc_nxt) begin
      err = ERR_FCRC;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.result_kind  = KIND_PAYLOAD;
    pay_res.payload_byte = oldest;
    pay_res.last_of_run  = ~item_eof;

    vrd_res                 = '0;
    vrd_res.result_kind     = KIND_VERDICT;
    vrd_res.frame_ok        = (err == ERR_NONE);
    vrd_res.error_code      = err;
    vrd_res.command_type    = header_nxt[7:0];
    vrd_res.sequence_number = header_nxt[23:8];
    vrd_res.command_set     = header_nxt[31:24];
    vrd_res.command_id      = header_nxt[39:32];
    vrd_res.payload_length  = (err == ERR_NONE) ? PLEN_W'(len - CW'(MIN_FRAME)) : '0;
    vrd_res.last_of_run     = 1'b1;
  end

  assign push.pay = item_valid && (byte_count_r >= CW'(MIN_FRAME));
  assign push.vrd = item_valid && item_eof;

  always_ff @(posedge clk) begin
    if (!rst_n || (item_valid && item_eof)) begin
      byte_count_r <= '0;
      header_crc_r <= HCRC_INIT;
      frame_crc_r  <= FCRC_INIT;
      length_r     <= '0;
      header_r     <= '0;
      first_err_r  <= ERR_NONE;
      for (int i = 0; i < 4; i++) begin
        window_r[i] <= '0;
      end
    end else if (item_valid) begin
      byte_count_r <= byte_count_nxt;
      header_crc_r <= header_crc_nxt;
      frame_crc_r  <= frame_crc_nxt;
      length_r     <= length_nxt;
      header_r     <= header_nxt;
      first_err_r  <= first_err_nxt;
      window_r[0]  <= window_r[1];
      window_r[1]  <= window_r[2];
      window_r[2]  <= window_r[3];
      window_r[3]  <= item_byte;
    end
  end

  `CFC_ASSERT_NXT(a_eof_clears_count, clk, rst_n, item_valid && item_eof, byte_count_r == '0)
  `CFC_ASSERT_NXT(a_count_advances, clk, rst_n, item_valid && !item_eof, byte_count_r != '0)

endmodule

FILE: rtl/cfc_rq.sv
// ---------------------------------------------------------------------------
// cfc_rq
// Four-entry result queue; takes up to two words per cycle, gives one per cycle while out_stall is low.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfc_rq (
  input  logic              clk,
  input  logic              rst_n,
  input  cfc_pkg::rq_push_t push,
  input  cfc_pkg::result_t  pay_res,
  input  cfc_pkg::result_t  vrd_res,
  output logic              out_valid,
  input  logic              out_stall,
  output cfc_pkg::result_t  head,
  output logic              room2
);
  import cfc_pkg::*;

  localparam int PTR_W = $clog2(RQ_DEPTH);
  localparam int CNT_W = $clog2(RQ_DEPTH + 1);

  result_t          entries_r [RQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_b;
  logic [CNT_W-1:0] count_r, count_nxt, n_push, avail;
  logic             pop;

  assign out_valid  = (count_r != '0);
  assign pop        = out_valid && !out_stall;
  assign head       = entries_r[rd_ptr_r];
  assign n_push     = CNT_W'(push.pay) + CNT_W'(push.vrd);
  assign avail      = count_r - CNT_W'(pop);
  assign room2      = (avail <= CNT_W'(RQ_DEPTH - 2));
  assign wr_b       = wr_ptr_r + PTR_W'(push.pay);
  assign count_nxt  = avail + n_push;
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < RQ_DEPTH; i++) begin
      if (push.pay && wr_ptr_r == PTR_W'(i)) begin
        entries_r[i] <= pay_res;
      end
      if (push.vrd && wr_b == PTR_W'(i)) begin
        entries_r[i] <= vrd_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `CFC_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(RQ_DEPTH))
  `CFC_ASSERT_IMP(a_push_room, clk, rst_n, push.pay || push.vrd, room2)

endmodule

FILE: rtl/command_frame_checker.sv
// ---------------------------------------------------------------------------
// command_frame_checker
// Streaming checker for command frames received one byte per word.
// ---------------------------------------------------------------------------
// One byte is taken per cycle while in_stall is low. A byte is held in the
// input register, then the frame logic (byte-wide CRC16 and CRC32 updates)
// writes up to two result words into a four-entry queue; payload bytes appear
// four bytes late, and the byte marked end of frame also gives the verdict
// word. Input stalls only while a byte waits in the input register and the
// queue lacks room for two words. start_byte resets to 0xAA.
`include "assert_macros.svh"

module command_frame_checker #(
  parameter int LENGTH_BITS = cfc_pkg::LENGTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [7:0]                 cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte_value,
  input  logic                       in_end_of_frame,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_result_kind,
  output logic [7:0]                 out_payload_byte,
  output logic                       out_frame_ok,
  output logic [2:0]                 out_error_code,
  output logic [7:0]                 out_command_type,
  output logic [15:0]                out_sequence_number,
  output logic [7:0]                 out_command_set,
  output logic [7:0]                 out_command_id,
  output logic [cfc_pkg::PLEN_W-1:0] out_payload_length,
  output logic                       out_last_of_run
);
  import cfc_pkg::*;

  logic [7:0] start_byte_r;
  logic       ireg_valid_r, ireg_valid_nxt;
  logic [7:0] ireg_byte_r;
  logic       ireg_eof_r;
  logic       room2, advance, in_accept;
  rq_push_t   push;
  result_t    pay_res, vrd_res, head;

  assign advance        = ireg_valid_r && room2;
  assign in_stall       = ireg_valid_r && !room2;
  assign in_accept      = in_valid && !in_stall;
  assign ireg_valid_nxt = in_accept || (ireg_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'hAA;
      ireg_valid_r <= 1'b0;
    end else begin
      ireg_valid_r <= ireg_valid_nxt;
      if (cfg_wr_en) begin
        start_byte_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ireg_byte_r <= in_byte_value;
      ireg_eof_r  <= in_end_of_frame;
    end
  end

  cfc_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(advance),
    .item_byte (ireg_byte_r),
    .item_eof  (ireg_eof_r),
    .start_byte(start_byte_r),
    .push      (push),
    .pay_res   (pay_res),
    .vrd_res   (vrd_res)
  );

  cfc_rq u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pay_res  (pay_res),
    .vrd_res  (vrd_res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head),
    .room2    (room2)
  );

  assign out_result_kind     = head.result_kind;
  assign out_payload_byte    = head.payload_byte;
  assign out_frame_ok        = head.frame_ok;
  assign out_error_code      = head.error_code;
  assign out_command_type    = head.command_type;
  assign out_sequence_number = head.sequence_number;
  assign out_command_set     = head.command_set;
  assign out_command_id      = head.command_id;
  assign out_payload_length  = head.payload_length;
  assign out_last_of_run     = head.last_of_run;

endmodule
